>>> src/itff_pkg.sv
package itff_pkg;

    // Field widths
    localparam int unsigned EX_W    = 8;
    localparam int unsigned LAP_W   = 10;
    localparam int unsigned SECS_W  = 17;
    localparam int unsigned LEN_W   = 16;
    localparam int unsigned COUNT_W = 9;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    // Limits
    localparam logic [LAP_W-1:0]   LAP_MAX   = 10'd1023;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd256;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WORK   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REST   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT = 2'd3;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } t_itff_state;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic out_load;
    } t_itff_cmd;

    // Datapath to controller
    typedef struct packed {
        logic bypass;
        logic step_done;
    } t_itff_status;

endpackage

>>> src/interval_timer_fast_forward.sv
// Requests with nothing to walk are passed through unchanged; otherwise the block
// walks forward one interval per step. A new request is accepted only in the idle
// state, after the previous result has gone to the result register; the walk
// advances one interval per cycle through a single step unit, up to about
// 65537 steps for the longest gap.
// Reset: synchronous, active low; clears the controller and the configuration
// registers to 0; position and result registers have no reset.
module interval_timer_fast_forward (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [itff_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [itff_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_phase_in,
    input  logic [itff_pkg::EX_W-1:0]             i_exercise_in,
    input  logic [itff_pkg::LAP_W-1:0]            i_lap_in,
    input  logic signed [itff_pkg::SECS_W-1:0]    i_seconds_left,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic                                  o_phase_out,
    output logic [itff_pkg::EX_W-1:0]             o_exercise_out,
    output logic [itff_pkg::LAP_W-1:0]            o_lap_out,
    output logic signed [itff_pkg::SECS_W-1:0]    o_seconds_out,
    output logic                                  o_finished
);

    itff_pkg::t_itff_cmd    w_cmd;
    itff_pkg::t_itff_status w_status;

    // Sequence the walk
    itff_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // Step through intervals
    itff_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_phase_in     (i_phase_in),
        .i_exercise_in  (i_exercise_in),
        .i_lap_in       (i_lap_in),
        .i_seconds_left (i_seconds_left),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .o_phase_out    (o_phase_out),
        .o_exercise_out (o_exercise_out),
        .o_lap_out      (o_lap_out),
        .o_seconds_out  (o_seconds_out),
        .o_finished     (o_finished)
    );

endmodule

>>> src/itff_ctrl.sv
module itff_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    input  itff_pkg::t_itff_status i_status,
    output itff_pkg::t_itff_cmd   o_cmd
);

    itff_pkg::t_itff_state r_state, n_state;
    logic                  r_out_valid, n_out_valid;
    logic                  w_in_fire;
    logic                  w_out_free;

    assign w_in_fire  = i_in_valid && (r_state == itff_pkg::ST_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;

    // State and output flag registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= itff_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_in_stall   = 1'b1;
        unique case (r_state)
            itff_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_status.bypass ? itff_pkg::ST_DONE : itff_pkg::ST_WALK;
                end
            end
            itff_pkg::ST_WALK: begin
                o_cmd.step = 1'b1;
                if (i_status.step_done) begin
                    n_state = itff_pkg::ST_DONE;
                end
            end
            itff_pkg::ST_DONE: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = itff_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = itff_pkg::ST_IDLE;
            end
        endcase
        // Hold result until taken
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    // A walking request always starts stepping next cycle
    a_walk_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && !i_status.bypass) |=> (r_state == itff_pkg::ST_WALK))
        else $error("walk did not start after accepted request");

    // Never overwrite a result that is still stalled
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || !i_out_stall))
        else $error("output overwritten while stalled");

    // Finished walk moves to handoff
    a_done_after_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == itff_pkg::ST_WALK && i_status.step_done) |=>
            (r_state == itff_pkg::ST_DONE))
        else $error("walk end missed");

    // A new result appears in the cycle after a handoff
    a_valid_after_handoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> r_out_valid)
        else $error("result not presented after handoff");

endmodule

>>> src/itff_dp.sv
module itff_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration
    input  logic                                  i_cfg_we,
    input  logic [itff_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [itff_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    // request fields
    input  logic                                  i_phase_in,
    input  logic [itff_pkg::EX_W-1:0]             i_exercise_in,
    input  logic [itff_pkg::LAP_W-1:0]            i_lap_in,
    input  logic signed [itff_pkg::SECS_W-1:0]    i_seconds_left,
    // control
    input  itff_pkg::t_itff_cmd                   i_cmd,
    output itff_pkg::t_itff_status                o_status,
    // result fields
    output logic                                  o_phase_out,
    output logic [itff_pkg::EX_W-1:0]             o_exercise_out,
    output logic [itff_pkg::LAP_W-1:0]            o_lap_out,
    output logic signed [itff_pkg::SECS_W-1:0]    o_seconds_out,
    output logic                                  o_finished
);

    // Configuration registers
    logic [itff_pkg::LEN_W-1:0]   r_cfg_work;
    logic [itff_pkg::LEN_W-1:0]   r_cfg_rest;
    logic [itff_pkg::COUNT_W-1:0] r_cfg_count;
    logic [itff_pkg::LAP_W-1:0]   r_cfg_repeat;

    // Working position
    logic                               r_phase, n_phase;
    logic [itff_pkg::EX_W-1:0]          r_ex, n_ex;
    logic [itff_pkg::LAP_W-1:0]         r_lap, n_lap;
    logic [itff_pkg::SECS_W-1:0]        r_over, n_over;
    logic signed [itff_pkg::SECS_W-1:0] r_secs, n_secs;
    logic                               r_fin, n_fin;

    // Result register
    logic                               r_o_phase;
    logic [itff_pkg::EX_W-1:0]          r_o_ex;
    logic [itff_pkg::LAP_W-1:0]         r_o_lap;
    logic signed [itff_pkg::SECS_W-1:0] r_o_secs;
    logic                               r_o_fin;

    logic [itff_pkg::COUNT_W-1:0] w_count;
    logic [itff_pkg::SECS_W-1:0]  w_neg;
    logic                         w_secs_pos;
    logic [itff_pkg::COUNT_W-1:0] w_ex_inc;
    logic                         w_wrap;
    logic [itff_pkg::EX_W-1:0]    w_ex_next;
    logic [itff_pkg::LAP_W-1:0]   w_lap_next;
    logic                         w_last;
    logic                         w_fin_step;
    logic [itff_pkg::LEN_W-1:0]   w_len;
    logic [itff_pkg::SECS_W-1:0]  w_len_x;
    logic                         w_land;

    // Write configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_work   <= '0;
            r_cfg_rest   <= '0;
            r_cfg_count  <= '0;
            r_cfg_repeat <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                itff_pkg::CFG_WORK:   r_cfg_work   <= i_cfg_data;
                itff_pkg::CFG_REST:   r_cfg_rest   <= i_cfg_data;
                itff_pkg::CFG_COUNT:  r_cfg_count  <= i_cfg_data[itff_pkg::COUNT_W-1:0];
                itff_pkg::CFG_REPEAT: r_cfg_repeat <= i_cfg_data[itff_pkg::LAP_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp exercise count, decide pass-through
    assign w_count    = (r_cfg_count > itff_pkg::COUNT_MAX) ? itff_pkg::COUNT_MAX : r_cfg_count;
    assign w_secs_pos = !i_seconds_left[itff_pkg::SECS_W-1] && (i_seconds_left != '0);
    assign w_neg      = (~$unsigned(i_seconds_left)) + 17'd1;
    assign o_status.bypass = (r_cfg_work == '0) || (r_cfg_count == '0) || w_secs_pos;

    // Advance exercise with lap wrap
    assign w_ex_inc   = {1'b0, r_ex} + 9'd1;
    assign w_wrap     = (w_ex_inc >= w_count);
    assign w_ex_next  = w_wrap ? '0 : w_ex_inc[itff_pkg::EX_W-1:0];
    assign w_lap_next = (w_wrap && (r_lap != itff_pkg::LAP_MAX)) ? (r_lap + 10'd1) : r_lap;

    // Last work interval of the last lap
    assign w_last     = (r_cfg_repeat != '0) && (r_lap >= r_cfg_repeat) && w_wrap;
    assign w_fin_step = !r_phase && w_last;

    // Length of the interval entered by this step
    assign w_len   = (!r_phase && (r_cfg_rest != '0)) ? r_cfg_rest : r_cfg_work;
    assign w_len_x = {1'b0, w_len};
    assign w_land  = (r_over < w_len_x);

    assign o_status.step_done = w_fin_step || w_land;

    // Next working position
    always_comb begin
        n_phase = r_phase;
        n_ex    = r_ex;
        n_lap   = r_lap;
        n_over  = r_over;
        n_secs  = r_secs;
        n_fin   = r_fin;
        if (i_cmd.load) begin
            n_phase = i_phase_in;
            n_ex    = i_exercise_in;
            n_lap   = i_lap_in;
            n_over  = w_neg;
            n_secs  = i_seconds_left;
            n_fin   = 1'b0;
        end else if (i_cmd.step) begin
            if (w_fin_step) begin
                n_fin  = 1'b1;
                n_secs = '0;
            end else begin
                if (!r_phase && (r_cfg_rest != '0)) begin
                    n_phase = 1'b1;
                end else begin
                    n_phase = 1'b0;
                    n_ex    = w_ex_next;
                    n_lap   = w_lap_next;
                end
                if (w_land) begin
                    n_secs = $signed(w_len_x - r_over);
                end else begin
                    n_over = r_over - w_len_x;
                end
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_phase <= n_phase;
        r_ex    <= n_ex;
        r_lap   <= n_lap;
        r_over  <= n_over;
        r_secs  <= n_secs;
        r_fin   <= n_fin;
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_phase <= r_phase;
            r_o_ex    <= r_ex;
            r_o_lap   <= r_lap;
            r_o_secs  <= r_secs;
            r_o_fin   <= r_fin;
        end
    end

    assign o_phase_out    = r_o_phase;
    assign o_exercise_out = r_o_ex;
    assign o_lap_out      = r_o_lap;
    assign o_seconds_out  = r_o_secs;
    assign o_finished     = r_o_fin;

endmodule

>>> tb/sv/itff_checker.sv
package itff_tb_pkg;
    import itff_pkg::*;

    // Interval phase codes
    typedef enum logic {
        PH_WORK = 1'b0,
        PH_REST = 1'b1
    } t_phase;

    // Position reported after a fast forward
    typedef struct packed {
        t_phase                   phase;
        logic [EX_W-1:0]          exercise;
        logic [LAP_W-1:0]         lap;
        logic signed [SECS_W-1:0] seconds;
        logic                     finished;
    } t_position;
endpackage

module itff_checker
    import itff_pkg::*;
    import itff_tb_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  logic                      i_phase_in,
    input  logic [EX_W-1:0]           i_exercise_in,
    input  logic [LAP_W-1:0]          i_lap_in,
    input  logic signed [SECS_W-1:0]  i_seconds_left,
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  logic                      i_phase_out,
    input  logic [EX_W-1:0]           i_exercise_out,
    input  logic [LAP_W-1:0]          i_lap_out,
    input  logic signed [SECS_W-1:0]  i_seconds_out,
    input  logic                      i_finished,
    output int                        o_pending,
    output int                        o_errors,
    output int                        o_checked,
    output int                        o_finished
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the timer program registers
    logic [LEN_W-1:0]   work_len;
    logic [LEN_W-1:0]   rest_len;
    logic [COUNT_W-1:0] ex_total;
    logic [LAP_W-1:0]   lap_total;

    t_position landing_q[$];
    int        err_count;
    int        checked_count;
    int        finished_count;

    assign o_errors   = err_count;
    assign o_checked  = checked_count;
    assign o_finished = finished_count;

    initial begin
        err_count      = 0;
        checked_count  = 0;
        finished_count = 0;
    end

    task automatic flag_mismatch(input string what);
        err_count++;
        $display("%0t ns mismatch: %s", $time, what);
    endtask

    // Move to the next exercise, wrapping into a new lap
    function automatic void step_exercise(inout int ex, inout int lap, input int count);
        ex = ex + 1;
        if (ex >= count) begin
            ex = 0;
            if (lap < int'(LAP_MAX))
                lap = lap + 1;
        end
    endfunction

    // Walk forward over every interval that ended during the gap
    function automatic t_position fast_forward(input t_phase phase,
                                               input logic [EX_W-1:0] ex_in,
                                               input logic [LAP_W-1:0] lap_in,
                                               input logic signed [SECS_W-1:0] left);
        t_position pos;
        int        count;
        int        ex;
        int        lap;
        int        over;
        int        span;
        logic      landed;
        count = (ex_total > COUNT_MAX) ? int'(COUNT_MAX) : int'(ex_total);
        ex    = int'(ex_in);
        lap   = int'(lap_in);
        pos.phase    = phase;
        pos.seconds  = left;
        pos.finished = 1'b0;
        if (work_len != 0 && count != 0 && left <= 0) begin
            over   = -int'(left);
            landed = 1'b0;
            span   = 0;
            while (!landed) begin
                if (pos.phase == PH_WORK) begin
                    if (lap_total != 0 && lap >= int'(lap_total) && ex + 1 >= count) begin
                        // last work interval of the last lap is over
                        pos.finished = 1'b1;
                        pos.seconds  = '0;
                        landed       = 1'b1;
                    end else if (rest_len == 0) begin
                        step_exercise(ex, lap, count);
                        span = int'(work_len);
                    end else begin
                        pos.phase = PH_REST;
                        span      = int'(rest_len);
                    end
                end else begin
                    step_exercise(ex, lap, count);
                    pos.phase = PH_WORK;
                    span      = int'(work_len);
                end
                if (!landed) begin
                    if (over < span) begin
                        pos.seconds = SECS_W'(span - over);
                        landed      = 1'b1;
                    end else begin
                        over = over - span;
                    end
                end
            end
        end
        pos.exercise = ex[EX_W-1:0];
        pos.lap      = lap[LAP_W-1:0];
        return pos;
    endfunction

    // Track register writes, predict each request, compare each result
    always @(posedge i_clk) begin : watch
        t_position got;
        t_position want;
        if (!i_rst_n) begin
            landing_q.delete();
            work_len  = '0;
            rest_len  = '0;
            ex_total  = '0;
            lap_total = '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_WORK:   work_len  = i_cfg_data[LEN_W-1:0];
                    CFG_REST:   rest_len  = i_cfg_data[LEN_W-1:0];
                    CFG_COUNT:  ex_total  = i_cfg_data[COUNT_W-1:0];
                    CFG_REPEAT: lap_total = i_cfg_data[LAP_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                got.phase    = t_phase'(i_phase_out);
                got.exercise = i_exercise_out;
                got.lap      = i_lap_out;
                got.seconds  = i_seconds_out;
                got.finished = i_finished;
                if (landing_q.size() == 0) begin
                    flag_mismatch($sformatf("result with no request pending: ex %0d lap %0d",
                                            got.exercise, got.lap));
                end else begin
                    want = landing_q.pop_front();
                    checked_count++;
                    if (want.finished)
                        finished_count++;
                    if (got.phase !== want.phase)
                        flag_mismatch($sformatf("result %0d phase: got %0d, expected %0d",
                                                checked_count, got.phase, want.phase));
                    if (got.exercise !== want.exercise)
                        flag_mismatch($sformatf("result %0d exercise: got %0d, expected %0d",
                                                checked_count, got.exercise, want.exercise));
                    if (got.lap !== want.lap)
                        flag_mismatch($sformatf("result %0d lap: got %0d, expected %0d",
                                                checked_count, got.lap, want.lap));
                    if (got.seconds !== want.seconds)
                        flag_mismatch($sformatf("result %0d seconds: got %0d, expected %0d",
                                                checked_count, got.seconds, want.seconds));
                    if (got.finished !== want.finished)
                        flag_mismatch($sformatf("result %0d finished: got %0d, expected %0d",
                                                checked_count, got.finished, want.finished));
                end
            end
            if (i_in_valid && !i_in_stall)
                landing_q.push_back(fast_forward(t_phase'(i_phase_in), i_exercise_in,
                                                 i_lap_in, i_seconds_left));
        end
        o_pending <= landing_q.size();
    end

endmodule

>>> tb/sv/tb.sv
module tb;
    import itff_pkg::*;
    import itff_tb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 300_000;
    localparam int MODE_LEN    = 450;

    logic                      i_clk;
    logic                      i_rst_n        = 1'b0;
    logic                      i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_index    = CFG_WORK;
    logic [CFG_DATA_W-1:0]     i_cfg_data     = '0;
    logic                      i_in_valid     = 1'b0;
    logic                      o_in_stall;
    logic                      i_phase_in     = 1'b0;
    logic [EX_W-1:0]           i_exercise_in  = '0;
    logic [LAP_W-1:0]          i_lap_in       = '0;
    logic signed [SECS_W-1:0]  i_seconds_left = '0;
    logic                      o_out_valid;
    logic                      i_out_stall    = 1'b0;
    logic                      o_phase_out;
    logic [EX_W-1:0]           o_exercise_out;
    logic [LAP_W-1:0]          o_lap_out;
    logic signed [SECS_W-1:0]  o_seconds_out;
    logic                      o_finished;

    int pending;
    int errors;
    int checked;
    int finished_runs;

    int send_idle_pct = 34;
    int recv_idle_pct = 68;
    int sent          = 0;
    int settings_used = 1;

    // Program currently loaded, used only to shape stimulus
    int cur_work   = 0;
    int cur_rest   = 0;
    int cur_count  = 0;
    int cur_repeat = 0;

    interval_timer_fast_forward u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_phase_in     (i_phase_in),
        .i_exercise_in  (i_exercise_in),
        .i_lap_in       (i_lap_in),
        .i_seconds_left (i_seconds_left),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_phase_out    (o_phase_out),
        .o_exercise_out (o_exercise_out),
        .o_lap_out      (o_lap_out),
        .o_seconds_out  (o_seconds_out),
        .o_finished     (o_finished)
    );

    itff_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_phase_in     (i_phase_in),
        .i_exercise_in  (i_exercise_in),
        .i_lap_in       (i_lap_in),
        .i_seconds_left (i_seconds_left),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_phase_out    (o_phase_out),
        .i_exercise_out (o_exercise_out),
        .i_lap_out      (o_lap_out),
        .i_seconds_out  (o_seconds_out),
        .i_finished     (o_finished),
        .o_pending      (pending),
        .o_errors       (errors),
        .o_checked      (checked),
        .o_finished     (finished_runs)
    );

    // 100 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Stall the result side at random
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // End the run when no handshake moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, pending);
        $display("FAIL interval_timer_fast_forward");
        $finish;
    end

    // Offer one request, with random idle cycles ahead of it
    task automatic push_request(input t_phase phase, input logic [EX_W-1:0] ex,
                                input logic [LAP_W-1:0] lap,
                                input logic signed [SECS_W-1:0] left);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_phase_in     <= phase;
        i_exercise_in  <= ex;
        i_lap_in       <= lap;
        i_seconds_left <= left;
        do @(posedge i_clk); while (o_in_stall);
        sent++;
        // swap the idle pattern, then drop idling altogether
        if (sent == MODE_LEN) begin
            send_idle_pct = 68;
            recv_idle_pct = 34;
        end else if (sent == 2 * MODE_LEN) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    endtask

    // Hold off until every expected result has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
    endtask

    // Load a whole program while the block is idle
    task automatic load_timer(input int work, input int rest, input int count, input int laps);
        drain();
        put_reg(CFG_WORK, CFG_DATA_W'(work));
        put_reg(CFG_REST, CFG_DATA_W'(rest));
        put_reg(CFG_COUNT, CFG_DATA_W'(count));
        put_reg(CFG_REPEAT, CFG_DATA_W'(laps));
        i_cfg_we   <= 1'b0;
        cur_work   = work;
        cur_rest   = rest;
        cur_count  = count;
        cur_repeat = laps;
        settings_used++;
    endtask

    // Random requests, mostly with gaps of a few intervals
    task automatic random_requests(input int n);
        int                       span;
        int                       bound;
        int                       roll;
        int                       ex_top;
        int                       lap_top;
        logic                     bypass;
        logic signed [SECS_W-1:0] left;
        bypass  = (cur_work == 0) || (cur_count == 0);
        span    = cur_work + cur_rest;
        ex_top  = (bypass || cur_count > 256) ? 255 : cur_count - 1;
        lap_top = bypass ? 1023 : (cur_repeat == 0 ? 3 : cur_repeat);
        for (int k = 0; k < n; k++) begin
            roll = $urandom_range(99);
            if (roll < 15) begin
                left = SECS_W'($urandom_range(65535, 1));
            end else if (roll < 20) begin
                left = '0;
            end else if (roll < 30 && (bypass || span >= 256)) begin
                left = SECS_W'(-int'($urandom_range(65535, 1)));
            end else begin
                bound = span * int'($urandom_range(12, 1));
                if (bound > 65535)
                    bound = 65535;
                left = SECS_W'(-int'($urandom_range(bound)));
            end
            push_request(t_phase'($urandom_range(1)),
                         EX_W'(($urandom_range(9) == 0) ? $urandom_range(255)
                                                        : $urandom_range(ex_top)),
                         LAP_W'(($urandom_range(9) == 0) ? $urandom_range(1023)
                                                         : $urandom_range(lap_top)),
                         left);
        end
    endtask

    initial begin : stimulus
        int roll;
        int work;
        int rest;
        int count;
        int laps;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Registers at reset: program misconfigured, requests pass through
        push_request(PH_WORK, 8'd255, 10'd1023, -17'sd65535);
        push_request(PH_REST, 8'd0, 10'd0, 17'sd0);
        push_request(PH_WORK, 8'd17, 10'd5, 17'sd65535);
        random_requests(40);

        // Short program: 4 exercises, 2 laps
        load_timer(3, 2, 4, 2);
        push_request(PH_WORK, 8'd0, 10'd0, 17'sd1);
        push_request(PH_WORK, 8'd0, 10'd0, 17'sd0);
        push_request(PH_REST, 8'd1, 10'd0, 17'sd0);
        push_request(PH_REST, 8'd3, 10'd0, 17'sd0);
        push_request(PH_WORK, 8'd0, 10'd0, -17'sd4);
        push_request(PH_WORK, 8'd3, 10'd2, 17'sd0);
        push_request(PH_WORK, 8'd255, 10'd5, 17'sd0);
        push_request(PH_REST, 8'd200, 10'd0, 17'sd0);
        push_request(PH_WORK, 8'd0, 10'd0, -17'sd65535);
        push_request(PH_REST, 8'd3, 10'd1, -17'sd3);
        random_requests(80);

        // No rest, endless laps: lap counter saturates
        load_timer(5, 0, 3, 0);
        push_request(PH_WORK, 8'd2, 10'd1022, -17'sd20);
        push_request(PH_REST, 8'd2, 10'd1023, -17'sd65535);
        random_requests(80);

        // Zero work length, then zero exercise count
        load_timer(0, 7, 5, 3);
        random_requests(40);
        load_timer(10, 4, 0, 3);
        random_requests(40);

        // Longest intervals, full exercise table, most laps
        load_timer(65535, 65535, 256, 1023);
        push_request(PH_WORK, 8'd255, 10'd1023, -17'sd65535);
        push_request(PH_REST, 8'd255, 10'd1022, -17'sd65535);
        random_requests(60);

        // One-second work, single exercise: longest walk
        load_timer(1, 0, 1, 0);
        push_request(PH_WORK, 8'd0, 10'd0, -17'sd65535);
        random_requests(30);

        // Exercise count beyond the table size
        load_timer(2, 1, 511, 1);
        push_request(PH_WORK, 8'd255, 10'd1, 17'sd0);
        random_requests(60);

        // Random programs
        for (int s = 0; s < 11; s++) begin
            roll = $urandom_range(99);
            work = (roll < 5) ? 0 : (roll < 15) ? $urandom_range(65535, 256)
                                                : $urandom_range(40, 1);
            roll = $urandom_range(99);
            rest = (roll < 30) ? 0 : (roll < 40) ? $urandom_range(65535, 256)
                                                 : $urandom_range(30, 1);
            roll = $urandom_range(99);
            count = (roll < 5) ? 0 : (roll < 15) ? 256
                  : (roll < 25) ? $urandom_range(511, 257) : $urandom_range(12, 1);
            roll = $urandom_range(99);
            laps = (roll < 25) ? 0 : (roll < 30) ? 1023 : $urandom_range(6, 1);
            load_timer(work, rest, count, laps);
            random_requests(80);
        end

        drain();
        repeat (16) @(posedge i_clk);

        $display("%0d requests over %0d timer programs, %0d results compared",
                 sent, settings_used, checked);
        $display("%0d walks ran to the end of the program", finished_runs);
        if (errors == 0 && pending == 0)
            $display("PASS interval_timer_fast_forward");
        else
            $display("FAIL interval_timer_fast_forward");
        $finish;
    end

endmodule
